// ----- design/pft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types, constants and format lookup functions for the pixel format
// transcoder.
// ----------------------------------------------------------------------------
package pft_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned FmtW   = 3;
  localparam int unsigned ColsW  = 13;
  localparam int unsigned PadW   = 16;
  localparam int unsigned PAddrW = 4;
  localparam int unsigned PDataW = 32;

  typedef enum logic [FmtW-1:0] {
    FMT_ABGR = 3'd0,
    FMT_ARGB = 3'd1,
    FMT_BGR  = 3'd2,
    FMT_BGRA = 3'd3,
    FMT_RGB  = 3'd4,
    FMT_RGBA = 3'd5
  } fmt_e;

  typedef enum logic [1:0] {
    REG_SRC_FORMAT   = 2'd0,
    REG_DST_FORMAT   = 2'd1,
    REG_COLUMNS      = 2'd2,
    REG_LINE_PADDING = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    CH_R = 2'd0,
    CH_G = 2'd1,
    CH_B = 2'd2,
    CH_A = 2'd3
  } chan_e;

  localparam logic [ByteW-1:0] AlphaOpaque = 8'hFF;

  // Unused codes fall back to RGBA
  function automatic fmt_e fmt_norm(input logic [FmtW-1:0] f);
    fmt_e r;
    r = (f > 3'd5) ? FMT_RGBA : fmt_e'(f);
    return r;
  endfunction

  function automatic logic [2:0] fmt_bpp(input fmt_e f);
    logic [2:0] n;
    case (f)
      FMT_BGR, FMT_RGB: n = 3'd3;
      default:          n = 3'd4;
    endcase
    return n;
  endfunction

  // Channel carried by byte position pos of format f
  function automatic chan_e fmt_chan(input fmt_e f, input logic [1:0] pos);
    chan_e c;
    case (f)
      FMT_ABGR: begin
        case (pos)
          2'd0:    c = CH_A;
          2'd1:    c = CH_B;
          2'd2:    c = CH_G;
          default: c = CH_R;
        endcase
      end
      FMT_ARGB: begin
        case (pos)
          2'd0:    c = CH_A;
          2'd1:    c = CH_R;
          2'd2:    c = CH_G;
          default: c = CH_B;
        endcase
      end
      FMT_BGR, FMT_BGRA: begin
        case (pos)
          2'd0:    c = CH_B;
          2'd1:    c = CH_G;
          2'd2:    c = CH_R;
          default: c = CH_A;
        endcase
      end
      default: begin
        case (pos)
          2'd0:    c = CH_R;
          2'd1:    c = CH_G;
          2'd2:    c = CH_B;
          default: c = CH_A;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

// ----- design/pft_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_in_if / pft_out_if
// Valid/ready channels of the pixel format transcoder: source bytes in,
// target bytes with framing flags out.
// ----------------------------------------------------------------------------
interface pft_in_if;
  logic                       valid;
  logic                       ready;
  logic [pft_pkg::ByteW-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface pft_out_if;
  logic                       valid;
  logic                       ready;
  logic [pft_pkg::ByteW-1:0]  out_byte;
  logic                       is_padding;
  logic                       row_end;
  logic                       last_of_run;

  modport source (output valid, output out_byte, output is_padding,
                  output row_end, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input is_padding,
                  input row_end, input last_of_run, output ready);
endinterface

// ----- design/pixel_format_transcoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_transcoder
// Re-orders a padded RGB/RGBA byte stream from one byte order to another.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one source byte per transfer (valid/ready).
//   out_o : one target byte per transfer, with is_padding, row_end and
//           last_of_run flags.
//   APB   : src_format @0x0, dst_format @0x4, columns @0x8,
//           line_padding @0xC. Write only while the stream is idle.
// Timing:
//   A byte that completes a pixel, or a padding byte, loads a result buffer
//   of up to four bytes; the first result is offered the cycle after the
//   input transfer, then one byte per cycle while out_o is ready. Bytes that
//   only collect into a pixel produce nothing and are taken every cycle,
//   also while the buffer drains. Collecting the next pixel overlaps the
//   drain, so the wider of source and target format sets the pace; the
//   single output port carries one byte at a time.
// Reset:
//   Registers return to RGBA -> RGBA, one column, no padding; the pixel
//   collector, column and padding counters clear and the buffer empties.
// Stall:
//   While out_o is stalled the current byte holds; a completing or padding
//   byte is refused unless the buffer is empty or its last byte is taken.
// ----------------------------------------------------------------------------
module pixel_format_transcoder #(
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pft_in_if.sink                       in_i,
  pft_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pft_pkg::PAddrW-1:0]   paddr,
  input  logic [pft_pkg::PDataW-1:0]   pwdata,
  output logic [pft_pkg::PDataW-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned CntW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned MaxW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned EffW = (MaxW > pft_pkg::ColsW) ? MaxW : pft_pkg::ColsW;
  localparam logic [EffW-1:0] MaxCols = EffW'(MAX_COLUMNS);

  // ---------------- configuration ----------------
  logic [pft_pkg::FmtW-1:0]  src_fmt_q, dst_fmt_q;
  logic [pft_pkg::ColsW-1:0] columns_q;
  logic [pft_pkg::PadW-1:0]  line_pad_q;
  logic                      cfg_we;
  pft_pkg::reg_e             reg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_sel = pft_pkg::reg_e'(paddr[pft_pkg::PAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q  <= pft_pkg::FMT_RGBA;
      dst_fmt_q  <= pft_pkg::FMT_RGBA;
      columns_q  <= pft_pkg::ColsW'(1);
      line_pad_q <= '0;
    end else if (cfg_we) begin
      case (reg_sel)
        pft_pkg::REG_SRC_FORMAT:   src_fmt_q  <= pwdata[pft_pkg::FmtW-1:0];
        pft_pkg::REG_DST_FORMAT:   dst_fmt_q  <= pwdata[pft_pkg::FmtW-1:0];
        pft_pkg::REG_COLUMNS:      columns_q  <= pwdata[pft_pkg::ColsW-1:0];
        pft_pkg::REG_LINE_PADDING: line_pad_q <= pwdata[pft_pkg::PadW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pft_pkg::REG_SRC_FORMAT:   prdata = pft_pkg::PDataW'(src_fmt_q);
      pft_pkg::REG_DST_FORMAT:   prdata = pft_pkg::PDataW'(dst_fmt_q);
      pft_pkg::REG_COLUMNS:      prdata = pft_pkg::PDataW'(columns_q);
      pft_pkg::REG_LINE_PADDING: prdata = pft_pkg::PDataW'(line_pad_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- stream state ----------------
  logic [pft_pkg::ByteW-1:0] pix_q [3];
  logic [1:0]                byte_idx_q, byte_idx_d;
  logic [CntW-1:0]           col_cnt_q, col_cnt_d;
  logic [pft_pkg::PadW-1:0]  pad_cnt_q, pad_cnt_d;
  logic                      in_pad_q, in_pad_d;

  // result buffer
  logic [pft_pkg::ByteW-1:0] res_q [4];
  logic [pft_pkg::ByteW-1:0] res_d [4];
  logic [2:0]                rem_q, rem_d;
  logic [1:0]                pos_q, pos_d;
  logic                      pad_q, pad_d;
  logic                      rend_q, rend_d;

  pft_pkg::fmt_e             sf, df;
  logic [2:0]                sbpp, dbpp;
  logic [EffW-1:0]           cols_ext, cols_eff;
  logic                      pix_last, produces, buf_free;
  logic                      in_fire, out_fire, pad_done, last_col;
  logic [pft_pkg::ByteW-1:0] src  [4];
  logic [pft_pkg::ByteW-1:0] chan [4];

  assign sf   = pft_pkg::fmt_norm(src_fmt_q);
  assign df   = pft_pkg::fmt_norm(dst_fmt_q);
  assign sbpp = pft_pkg::fmt_bpp(sf);
  assign dbpp = pft_pkg::fmt_bpp(df);

  assign cols_ext = EffW'(columns_q);
  always_comb begin
    if (columns_q == '0) begin
      cols_eff = EffW'(1);
    end else if (cols_ext > MaxCols) begin
      cols_eff = MaxCols;
    end else begin
      cols_eff = cols_ext;
    end
  end

  assign last_col = ((EffW+1)'(col_cnt_q) + (EffW+1)'(1)) >= (EffW+1)'(cols_eff);
  assign pad_done = ((pft_pkg::PadW+1)'(pad_cnt_q) + (pft_pkg::PadW+1)'(1))
                    >= (pft_pkg::PadW+1)'(line_pad_q);

  // Whether the next byte yields results depends on state only, not on data
  assign pix_last = (3'(byte_idx_q) + 3'd1) >= sbpp;
  assign produces = in_pad_q | pix_last;
  assign buf_free = (rem_q == 3'd0) | ((rem_q == 3'd1) & out_o.ready);

  assign in_i.ready = ~produces | buf_free;
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_fire   = out_o.valid & out_o.ready;

  // Decode source pixel into channels, then lay out in target order
  always_comb begin
    src[0] = pix_q[0];
    src[1] = pix_q[1];
    src[2] = (sbpp == 3'd3) ? in_i.in_byte : pix_q[2];
    src[3] = in_i.in_byte;
    for (int i = 0; i < 4; i++) begin
      chan[i] = '0;
    end
    chan[pft_pkg::CH_A] = pft_pkg::AlphaOpaque;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < sbpp) begin
        chan[pft_pkg::fmt_chan(sf, 2'(i))] = src[i];
      end
    end
  end

  always_comb begin
    byte_idx_d = byte_idx_q;
    col_cnt_d  = col_cnt_q;
    pad_cnt_d  = pad_cnt_q;
    in_pad_d   = in_pad_q;
    rem_d      = rem_q;
    pos_d      = pos_q;
    pad_d      = pad_q;
    rend_d     = rend_q;
    res_d      = res_q;

    if (out_fire) begin
      rem_d = rem_q - 3'd1;
      pos_d = pos_q + 2'd1;
    end

    if (in_fire) begin
      if (in_pad_q) begin
        res_d[0] = in_i.in_byte;
        rem_d    = 3'd1;
        pos_d    = 2'd0;
        pad_d    = 1'b1;
        rend_d   = pad_done;
        if (pad_done) begin
          in_pad_d  = 1'b0;
          pad_cnt_d = '0;
          col_cnt_d = '0;
        end else begin
          pad_cnt_d = pad_cnt_q + pft_pkg::PadW'(1);
        end
      end else if (!pix_last) begin
        byte_idx_d = byte_idx_q + 2'd1;
      end else begin
        for (int i = 0; i < 4; i++) begin
          res_d[i] = chan[pft_pkg::fmt_chan(df, 2'(i))];
        end
        rem_d      = dbpp;
        pos_d      = 2'd0;
        pad_d      = 1'b0;
        rend_d     = last_col & (line_pad_q == '0);
        byte_idx_d = 2'd0;
        if (last_col) begin
          col_cnt_d = '0;
          if (line_pad_q != '0) begin
            in_pad_d  = 1'b1;
            pad_cnt_d = '0;
          end
        end else begin
          col_cnt_d = col_cnt_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q <= '0;
      col_cnt_q  <= '0;
      pad_cnt_q  <= '0;
      in_pad_q   <= 1'b0;
      rem_q      <= '0;
      pos_q      <= '0;
    end else begin
      byte_idx_q <= byte_idx_d;
      col_cnt_q  <= col_cnt_d;
      pad_cnt_q  <= pad_cnt_d;
      in_pad_q   <= in_pad_d;
      rem_q      <= rem_d;
      pos_q      <= pos_d;
    end
  end

  // Payload: no reset, qualified by rem_q
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    pad_q  <= pad_d;
    rend_q <= rend_d;
    if (in_fire && !in_pad_q && !pix_last && (byte_idx_q != 2'd3)) begin
      pix_q[byte_idx_q] <= in_i.in_byte;
    end
  end

  assign out_o.valid       = (rem_q != 3'd0);
  assign out_o.out_byte    = res_q[pos_q];
  assign out_o.is_padding  = pad_q;
  assign out_o.last_of_run = (rem_q == 3'd1);
  assign out_o.row_end     = rend_q & (rem_q == 3'd1);

endmodule

// ----- design/pft_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_checker
// Port-level checks on the transcoder's output channel, bound to the top.
// ----------------------------------------------------------------------------
module pft_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [pft_pkg::ByteW-1:0] out_byte_i,
  input logic                      is_padding_i,
  input logic                      row_end_i,
  input logic                      last_of_run_i
);

  // stalled transfer keeps valid
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped while stalled");

  // stalled transfer keeps its byte
  a_byte_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_byte_i))
    else $error("output byte changed while stalled");

  // row end only on the closing byte of a run
  a_rend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && row_end_i) |-> last_of_run_i)
    else $error("row_end without last_of_run");

  // a padding byte is always a run of one
  a_pad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && is_padding_i) |-> last_of_run_i)
    else $error("padding byte not closing its run");

  // a pixel burst continues without a gap
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_of_run_i) |=> out_valid_i)
    else $error("pixel run broken before its last byte");

endmodule

bind pixel_format_transcoder pft_checker u_pft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .is_padding_i  (out_o.is_padding),
  .row_end_i     (out_o.row_end),
  .last_of_run_i (out_o.last_of_run)
);
